### src/ggc_pkg.sv
`default_nettype none

package ggc_pkg;

  // graph size limits and field widths
  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COLOR_W   = 7;
  localparam int COUNT_W   = 7;
  localparam int SUM_W     = 13;
  localparam int ROW_W     = 64;
  localparam int SIZE_W    = 7;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(64);
  localparam logic [COUNT_W-1:0] NODE_COUNT_MAX   = COUNT_W'(MAX_NODES);

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_COMMIT
  } ggc_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take_row;
    logic pick;
    logic commit;
  } ggc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic res_busy;
  } ggc_stat_t;

endpackage

`default_nettype wire

### src/ggc_row_if.sv
`default_nettype none

interface ggc_row_if;
  logic                    valid;
  logic                    ready;
  logic [ggc_pkg::ROW_W-1:0] neighbor_bits;

  modport source (output valid, output neighbor_bits, input ready);
  modport sink   (input valid, input neighbor_bits, output ready);
endinterface

`default_nettype wire

### src/ggc_res_if.sv
`default_nettype none

interface ggc_res_if;
  logic                        valid;
  logic                        ready;
  logic [ggc_pkg::NODE_W-1:0]  node_index;
  logic [ggc_pkg::COLOR_W-1:0] node_color;
  logic [ggc_pkg::COLOR_W-1:0] colors_used;
  logic [ggc_pkg::SUM_W-1:0]   square_sum;
  logic                        last_node;

  modport source (output valid, output node_index, output node_color,
                  output colors_used, output square_sum, output last_node,
                  input ready);
  modport sink   (input valid, input node_index, input node_color,
                  input colors_used, input square_sum, input last_node,
                  output ready);
endinterface

`default_nettype wire

### src/ggc_ram.sv
`default_nettype none

module ggc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/ggc_ctrl.sv
`default_nettype none

module ggc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              row_valid,
  output logic                   row_ready,
  input  wire ggc_pkg::ggc_stat_t stat,
  output ggc_pkg::ggc_cmd_t      cmd
);

  ggc_pkg::ggc_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ggc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    row_ready    = 1'b0;
    cmd.take_row = 1'b0;
    cmd.pick     = 1'b0;
    cmd.commit   = 1'b0;
    case (state)
      ggc_pkg::ST_IDLE: begin
        row_ready = 1'b1;
        if (row_valid) begin
          cmd.take_row = 1'b1;
          state_next   = ggc_pkg::ST_PICK;
        end
      end
      ggc_pkg::ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = ggc_pkg::ST_COMMIT;
      end
      ggc_pkg::ST_COMMIT: begin
        // hold until the output register can take the result
        if (!stat.res_busy) begin
          cmd.commit = 1'b1;
          state_next = ggc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ggc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/ggc_dp.sv
`default_nettype none

module ggc_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ggc_pkg::ggc_cmd_t               cmd,
  output ggc_pkg::ggc_stat_t                   stat,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ggc_pkg::COUNT_W-1:0]     cfg_wr_data,
  input  wire logic [ggc_pkg::ROW_W-1:0]       neighbor_bits,
  ggc_res_if.source                            result
);

  localparam int N  = ggc_pkg::MAX_NODES;
  localparam int NW = ggc_pkg::NODE_W;

  // stored colors, kept as color minus one; only entries below the row index are read
  logic [NW-1:0]                 color_store [N];
  logic [N-1:0]                  class_valid;
  logic [N-1:0]                  taken;
  logic [ggc_pkg::COLOR_W-1:0]   color;
  logic [ggc_pkg::COLOR_W-1:0]   max_color;
  logic [NW-1:0]                 row_counter;
  logic [ggc_pkg::SUM_W-1:0]     sum;
  logic [ggc_pkg::COUNT_W-1:0]   node_count;
  logic                          out_valid;

  logic [N-1:0]                  taken_next;
  logic [N-1:0]                  free_bits;
  logic [N-1:0]                  lowest_free;
  logic [NW-1:0]                 pick_idx;
  logic [ggc_pkg::SIZE_W-1:0]    ram_rd_data;
  logic [ggc_pkg::SIZE_W-1:0]    class_size;
  logic [NW-1:0]                 color_idx;
  logic [ggc_pkg::COLOR_W-1:0]   max_color_next;
  logic [ggc_pkg::SUM_W-1:0]     sum_next;
  logic [ggc_pkg::COUNT_W-1:0]   eff_count;
  logic [ggc_pkg::COUNT_W-1:0]   row_plus_one;
  logic                          last;

  // colors held by earlier neighbors
  always_comb begin
    taken_next = '0;
    for (int j = 0; j < N; j++) begin
      if (neighbor_bits[j] && (NW'(j) < row_counter)) begin
        taken_next[color_store[j]] = 1'b1;
      end
    end
  end

  // first free color: isolate lowest zero, top color always counts as free
  always_comb begin
    free_bits   = {1'b0, taken[N-2:0]};
    lowest_free = ~free_bits & (free_bits + N'(1));
    pick_idx    = '0;
    for (int k = 0; k < N; k++) begin
      if (lowest_free[k]) begin
        pick_idx = pick_idx | NW'(k);
      end
    end
  end

  // class size lookup and running totals
  assign color_idx      = color[NW-1:0] - NW'(1);
  assign class_size     = class_valid[color_idx] ? ram_rd_data : '0;
  assign max_color_next = (color > max_color) ? color : max_color;
  assign sum_next       = sum + ggc_pkg::SUM_W'({class_size, 1'b1});

  // last row test against the clamped node count
  always_comb begin
    if (node_count == '0) begin
      eff_count = ggc_pkg::COUNT_W'(1);
    end else if (node_count > ggc_pkg::NODE_COUNT_MAX) begin
      eff_count = ggc_pkg::NODE_COUNT_MAX;
    end else begin
      eff_count = node_count;
    end
  end
  assign row_plus_one = {1'b0, row_counter} + ggc_pkg::COUNT_W'(1);
  assign last         = row_plus_one >= eff_count;

  assign stat.res_busy = out_valid && !result.ready;

  ggc_ram #(
    .WIDTH (ggc_pkg::SIZE_W),
    .DEPTH (N)
  ) u_class_ram (
    .clk     (clk),
    .wr_en   (cmd.commit),
    .wr_addr (color_idx),
    .wr_data (class_size + ggc_pkg::SIZE_W'(1)),
    .rd_en   (cmd.pick),
    .rd_addr (pick_idx),
    .rd_data (ram_rd_data)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_row) begin
      taken <= taken_next;
    end
    if (cmd.pick) begin
      color <= {1'b0, pick_idx} + ggc_pkg::COLOR_W'(1);
    end
    if (cmd.commit) begin
      color_store[row_counter] <= color_idx;
      result.node_index        <= row_counter;
      result.node_color        <= color;
      result.colors_used       <= max_color_next;
      result.square_sum        <= sum_next;
      result.last_node         <= last;
    end
  end

  // graph state, config register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      class_valid <= '0;
      max_color   <= '0;
      row_counter <= '0;
      sum         <= '0;
      node_count  <= ggc_pkg::NODE_COUNT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (last) begin
          class_valid <= '0;
          max_color   <= '0;
          row_counter <= '0;
          sum         <= '0;
        end else begin
          class_valid[color_idx] <= 1'b1;
          max_color              <= max_color_next;
          row_counter            <= row_counter + NW'(1);
          sum                    <= sum_next;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;

endmodule

`default_nettype wire

### src/greedy_graph_coloring_top.sv
// each row passes through gather of neighbor colors, first-fit pick with class size
//   read from the class ram, and commit; the next row is taken only after commit,
//   and commit waits while the previous result is still held
// reset: synchronous active-high rst clears the graph and sets node_count to 64;
//   no clearing pass, class entries use valid flops
`default_nettype none

module greedy_graph_coloring_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [ggc_pkg::COUNT_W-1:0] cfg_wr_data,
  ggc_row_if.sink                          row,
  ggc_res_if.source                        result
);

  ggc_pkg::ggc_cmd_t  cmd;
  ggc_pkg::ggc_stat_t stat;

  // sequencing
  ggc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .row_valid (row.valid),
    .row_ready (row.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // coloring datapath
  ggc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .neighbor_bits (row.neighbor_bits),
    .result        (result)
  );

endmodule

`default_nettype wire
